// ----- rtl/core/aavr_pkg.sv -----
// aavr_pkg: shared constants, types and elaboration-time constant builders
// for the axis-angle vector rotator. No dependencies.

package aavr_pkg;

	localparam int CORDIC_ITERATIONS = 24;
	// angle fold, scale, round, CORDIC steps, trig output
	localparam int FRONT_LAT = CORDIC_ITERATIONS + 4;
	localparam int LANE_LAT  = 6;
	localparam int TOTAL_LAT = FRONT_LAT + LANE_LAT;

	localparam int CW = 44;  // CORDIC datapath, Q40
	localparam int TW = 34;  // cos/sin/(1-cos), Q30

	typedef logic signed [31:0] tri_t [3];

	typedef struct packed {
		logic signed [TW-1:0] c;
		logic signed [TW-1:0] s;
		logic signed [TW-1:0] t;
	} trig_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               sat;
	} lane_res_t;

	// shift-subtract quotient, evaluated only while building constants
	function automatic logic [63:0] cdiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [63:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// atan(1/n) in Q62 by the alternating series
	function automatic logic [63:0] atan_recip_q62(input logic [63:0] n);
		logic [63:0] p;
		logic [63:0] n2;
		logic [63:0] sum;
		logic [63:0] term;
		p    = cdiv64(64'h4000_0000_0000_0000, n);
		n2   = n * n;
		sum  = '0;
		term = '0;
		for (int k = 0; k < 64; k++) begin
			if (p != 64'd0) begin
				term = cdiv64(p, 64'(2 * k + 1));
				if (k[0])
					sum = sum - term;
				else
					sum = sum + term;
				p = cdiv64(p, n2);
			end
		end
		return sum;
	endfunction

	function automatic logic [63:0] quarter_pi_q62();
		return (64'd4 * atan_recip_q62(64'd5)) - atan_recip_q62(64'd239);
	endfunction

	function automatic logic [CW-1:0] atan_q40(input int i);
		logic [63:0] v;
		if (i == 0)
			v = quarter_pi_q62();
		else
			v = atan_recip_q62(64'd1 << i);
		return CW'((v + (64'd1 << 21)) >> 22);
	endfunction

	function automatic logic [34:0] deg_to_rad_q40();
		logic [63:0] v;
		v = cdiv64(64'd4 * quarter_pi_q62(), 64'd180);
		return 35'((v + (64'd1 << 21)) >> 22);
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] val);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = val;
		r = '0;
		b = 64'd1 << 62;
		for (int n = 0; n < 32; n++)
			if (b > v)
				b = b >> 2;
		for (int n = 0; n < 32; n++) begin
			if (b != 64'd0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	function automatic logic [CW-1:0] inv_gain_q40();
		logic [63:0] g;
		logic [63:0] k31;
		g = 64'd1 << 62;
		for (int i = 0; i < CORDIC_ITERATIONS; i++)
			g = g + (g >> (2 * i));
		k31 = isqrt64(g);
		return CW'(cdiv64((64'd1 << 63) + (k31 >> 1), k31) << 8);
	endfunction

	function automatic logic signed [31:0] clamp_axis(input logic signed [31:0] a);
		if (a > 32'sd1073741824)
			return 32'sd1073741824;
		if (a < -32'sd1073741824)
			return -32'sd1073741824;
		return a;
	endfunction

endpackage

// ----- rtl/core/aavr_item_if.sv -----
// aavr_item_if: input channel of the rotator (vector, axis, angle).
// Depends on nothing.

interface aavr_item_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;
	logic signed [31:0] vec_z;
	logic signed [31:0] axis_x;
	logic signed [31:0] axis_y;
	logic signed [31:0] axis_z;
	logic signed [25:0] angle_deg;

	modport source (output valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_deg,
		input ready);
	modport sink (input valid, vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_deg,
		output ready);
endinterface

// ----- rtl/core/aavr_result_if.sv -----
// aavr_result_if: output channel of the rotator (rotated vector, clamp flag).
// Depends on nothing.

interface aavr_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] rot_x;
	logic signed [31:0] rot_y;
	logic signed [31:0] rot_z;
	logic               saturated;

	modport source (output valid, rot_x, rot_y, rot_z, saturated, input ready);
	modport sink (input valid, rot_x, rot_y, rot_z, saturated, output ready);
endinterface

// ----- rtl/core/axis_angle_vector_rotate.sv -----
// Axis-angle (Rodrigues) vector rotator. Takes one item per cycle when not
// stalled: the angle is folded and fed through a 24-step CORDIC unrolled
// one step per stage, then three row lanes each build one matrix row and
// its dot product with the vector in six stages. The CORDIC chain makes up
// most of the pipeline. Sustained rate is one transfer per cycle. A two-entry
// result queue keeps the pipeline moving while one result waits; the whole
// pipeline holds only when the queue is full and the sink is not ready.
// No clearing pass.
// Depends on aavr_pkg, aavr_item_if, aavr_result_if, aavr_cordic, aavr_lane.

module axis_angle_vector_rotate import aavr_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	aavr_item_if.sink     item,
	aavr_result_if.source result
);

	typedef struct packed {
		logic signed [31:0] rot_x;
		logic signed [31:0] rot_y;
		logic signed [31:0] rot_z;
		logic               saturated;
	} rot_res_t;

	logic                 en;
	logic [TOTAL_LAT-1:0] vld_q;
	logic [1:0]           cnt_q;
	logic                 wr_q, rd_q;
	rot_res_t             fifo_q [2];
	logic                 push, pop;

	assign en         = (cnt_q != 2'd2) || result.ready;
	assign item.ready = en;
	assign push       = vld_q[TOTAL_LAT-1] && en;
	assign pop        = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[TOTAL_LAT-2:0], item.valid};
	end

	// axis and vector ride alongside the CORDIC
	tri_t axis_dl_q [FRONT_LAT];
	tri_t vec_dl_q  [FRONT_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			axis_dl_q[0][0] <= clamp_axis(item.axis_x);
			axis_dl_q[0][1] <= clamp_axis(item.axis_y);
			axis_dl_q[0][2] <= clamp_axis(item.axis_z);
			vec_dl_q[0][0]  <= item.vec_x;
			vec_dl_q[0][1]  <= item.vec_y;
			vec_dl_q[0][2]  <= item.vec_z;
			for (int n = 1; n < FRONT_LAT; n++) begin
				axis_dl_q[n] <= axis_dl_q[n-1];
				vec_dl_q[n]  <= vec_dl_q[n-1];
			end
		end
	end

	trig_t trig;

	aavr_cordic u_cordic (
		.clk   (clk),
		.en    (en),
		.angle (item.angle_deg),
		.trig  (trig)
	);

	lane_res_t lane_res [3];

	for (genvar r = 0; r < 3; r++) begin : g_lane
		aavr_lane u_lane (
			.clk  (clk),
			.en   (en),
			.row  (2'(r)),
			.trig (trig),
			.axis (axis_dl_q[FRONT_LAT-1]),
			.vec  (vec_dl_q[FRONT_LAT-1]),
			.res  (lane_res[r])
		);
	end

	// merge lanes into the result queue
	rot_res_t merged;

	always_comb begin
		merged.rot_x     = lane_res[0].value;
		merged.rot_y     = lane_res[1].value;
		merged.rot_z     = lane_res[2].value;
		merged.saturated = lane_res[0].sat | lane_res[1].sat | lane_res[2].sat;
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_q] <= merged;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign result.valid     = cnt_q != 2'd0;
	assign result.rot_x     = fifo_q[rd_q].rot_x;
	assign result.rot_y     = fifo_q[rd_q].rot_y;
	assign result.rot_z     = fifo_q[rd_q].rot_z;
	assign result.saturated = fifo_q[rd_q].saturated;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != 2'd2) || pop)
		else $error("transfer into full result queue");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved while stalled");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> wr_q == rd_q)
		else $error("queue pointers disagree with count");

endmodule

// ----- rtl/core/aavr_cordic.sv -----
// aavr_cordic: angle fold to [-90,90] deg, degree->radian scale, unrolled
// rotation-mode CORDIC, one step per stage. Output cos, sin, 1-cos in Q30.
// Depends on aavr_pkg.

module aavr_cordic import aavr_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [25:0] angle,
	output trig_t              trig
);

	localparam logic signed [26:0] FULL_TURN    = 27'sd23592960;
	localparam logic signed [26:0] HALF_TURN    = 27'sd11796480;
	localparam logic signed [26:0] QUARTER_TURN = 27'sd5898240;
	localparam logic signed [26:0] TQ_TURN      = 27'sd17694720;
	localparam logic [34:0]        DEG2RAD      = deg_to_rad_q40();
	localparam logic signed [CW-1:0] INV_GAIN   = signed'(inv_gain_q40());

	// stage 1: reduce mod 360 and fold
	logic signed [26:0] a0, r0, r1, red, fold;
	logic               flip;
	logic signed [23:0] ang_s1;
	logic               flip_s1;

	always_comb begin
		a0 = 27'(angle);
		r0 = a0 + FULL_TURN;
		r1 = (r0 < 0) ? r0 + FULL_TURN : r0;
		if (a0 >= FULL_TURN)
			red = a0 - FULL_TURN;
		else if (a0 < 0)
			red = r1;
		else
			red = a0;
		flip = 1'b0;
		if (red >= TQ_TURN)
			fold = red - FULL_TURN;
		else if (red > QUARTER_TURN) begin
			fold = red - HALF_TURN;
			flip = 1'b1;
		end else
			fold = red;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1  <= 24'(fold);
			flip_s1 <= flip;
		end
	end

	// stage 2: magnitude times pi/180
	logic [22:0] mag;
	logic [57:0] prod_s2;
	logic        neg_s2, flip_s2;

	assign mag = 23'((ang_s1 < 0) ? -ang_s1 : ang_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= 58'(mag) * 58'(DEG2RAD);
			neg_s2  <= ang_s1 < 0;
			flip_s2 <= flip_s1;
		end
	end

	// stage 3: round to Q40 radians
	logic [41:0]          zmag;
	logic signed [CW-1:0] zpos;
	logic signed [CW-1:0] z_s3;
	logic                 flip_s3;

	assign zmag = 42'((prod_s2 + 58'd32768) >> 16);
	assign zpos = signed'({2'b00, zmag});

	always_ff @(posedge clk) begin
		if (en) begin
			z_s3    <= neg_s2 ? -zpos : zpos;
			flip_s3 <= flip_s2;
		end
	end

	// CORDIC steps
	logic signed [CW-1:0] x_sn [1:CORDIC_ITERATIONS];
	logic signed [CW-1:0] y_sn [1:CORDIC_ITERATIONS];
	logic signed [CW-1:0] z_sn [1:CORDIC_ITERATIONS];
	logic                 f_sn [1:CORDIC_ITERATIONS];

	for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_step
		localparam logic signed [CW-1:0] ATAN_G = signed'(atan_q40(g));
		logic signed [CW-1:0] xin, yin, zin;
		logic                 fin;
		if (g == 0) begin : g_first
			assign xin = INV_GAIN;
			assign yin = '0;
			assign zin = z_s3;
			assign fin = flip_s3;
		end else begin : g_next
			assign xin = x_sn[g];
			assign yin = y_sn[g];
			assign zin = z_sn[g];
			assign fin = f_sn[g];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (zin >= 0) begin
					x_sn[g+1] <= xin - (yin >>> g);
					y_sn[g+1] <= yin + (xin >>> g);
					z_sn[g+1] <= zin - ATAN_G;
				end else begin
					x_sn[g+1] <= xin + (yin >>> g);
					y_sn[g+1] <= yin - (xin >>> g);
					z_sn[g+1] <= zin + ATAN_G;
				end
				f_sn[g+1] <= fin;
			end
		end
	end

	// final: round to Q30, undo the half-turn fold
	logic signed [CW-1:0] xr, yr;
	logic signed [TW-1:0] c_r, s_r, c_f, s_f;

	always_comb begin
		xr  = (x_sn[CORDIC_ITERATIONS] + 44'sd512) >>> 10;
		yr  = (y_sn[CORDIC_ITERATIONS] + 44'sd512) >>> 10;
		c_r = TW'(xr);
		s_r = TW'(yr);
		c_f = f_sn[CORDIC_ITERATIONS] ? -c_r : c_r;
		s_f = f_sn[CORDIC_ITERATIONS] ? -s_r : s_r;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trig.c <= c_f;
			trig.s <= s_f;
			trig.t <= 34'sd1073741824 - c_f;
		end
	end

endmodule

// ----- rtl/core/aavr_lane.sv -----
// aavr_lane: one output component. Builds one row of the rotation matrix
// and takes its dot product with the vector, then rounds and clamps.
// Depends on aavr_pkg.

module aavr_lane import aavr_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [1:0]  row,
	input  trig_t       trig,
	input  tri_t        axis,
	input  tri_t        vec,
	output lane_res_t   res
);

	localparam int MW = TW + 1;

	logic [1:0] nxt;
	assign nxt = (row == 2'd2) ? 2'd0 : row + 2'd1;

	// stage 1: a_row*a_j and s*a_k
	logic signed [63:0]   aa [3];
	logic signed [65:0]   as [3];
	logic [1:0]           kk [3];
	logic signed [31:0]   q_s1 [3];
	logic signed [TW-1:0] sa_s1 [3];
	logic signed [TW-1:0] c_s1, t_s1;
	tri_t                 v_s1;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			kk[j] = 2'd3 - row - 2'(j);
			if (kk[j] == 2'd3)
				kk[j] = 2'd0;
			aa[j] = 64'(axis[row]) * 64'(axis[j]);
			as[j] = 66'(axis[kk[j]]) * 66'(trig.s);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				q_s1[j]  <= 32'((aa[j] + 64'sd536870912) >>> 30);
				sa_s1[j] <= TW'((as[j] + 66'sd536870912) >>> 30);
			end
			c_s1 <= trig.c;
			t_s1 <= trig.t;
			v_s1 <= vec;
		end
	end

	// stage 2: (1-c) * a_row*a_j
	logic signed [65:0]   pt [3];
	logic signed [TW-1:0] p_s2 [3];
	logic signed [TW-1:0] sa_s2 [3];
	logic signed [TW-1:0] c_s2;
	tri_t                 v_s2;

	always_comb
		for (int j = 0; j < 3; j++)
			pt[j] = 66'(t_s1) * 66'(q_s1[j]);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++)
				p_s2[j] <= TW'((pt[j] + 66'sd536870912) >>> 30);
			sa_s2 <= sa_s1;
			c_s2  <= c_s1;
			v_s2  <= v_s1;
		end
	end

	// stage 3: matrix entries; cyclic off-diagonal takes -s*a_k
	logic signed [MW-1:0] m_s3 [3];
	tri_t                 v_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				if (2'(j) == row)
					m_s3[j] <= MW'(c_s2) + MW'(p_s2[j]);
				else if (2'(j) == nxt)
					m_s3[j] <= MW'(p_s2[j]) - MW'(sa_s2[j]);
				else
					m_s3[j] <= MW'(p_s2[j]) + MW'(sa_s2[j]);
			end
			v_s3 <= v_s2;
		end
	end

	// stage 4: entry times component, Q46 -> Q44
	logic signed [66:0] mv [3];
	logic signed [64:0] pr_s4 [3];

	always_comb
		for (int j = 0; j < 3; j++)
			mv[j] = 67'(m_s3[j]) * 67'(v_s3[j]);

	always_ff @(posedge clk) begin
		if (en)
			for (int j = 0; j < 3; j++)
				pr_s4[j] <= 65'(mv[j] >>> 2);
	end

	// stage 5: sum
	logic signed [66:0] acc_s5;

	always_ff @(posedge clk) begin
		if (en)
			acc_s5 <= 67'(pr_s4[0]) + 67'(pr_s4[1]) + 67'(pr_s4[2]);
	end

	// stage 6: round to Q16.16 and clamp
	logic signed [38:0] r;

	assign r = 39'((acc_s5 + 67'sd134217728) >>> 28);

	always_ff @(posedge clk) begin
		if (en) begin
			if (r > 39'sd2147483647) begin
				res.value <= 32'sh7fff_ffff;
				res.sat   <= 1'b1;
			end else if (r < -39'sd2147483648) begin
				res.value <= 32'sh8000_0000;
				res.sat   <= 1'b1;
			end else begin
				res.value <= 32'(r);
				res.sat   <= 1'b0;
			end
		end
	end

endmodule
